@@ design/diode_clipper_log_shaper_core_defines.svh @@
// Assertion macros used by the asserting file of the clipper core.
// Each macro samples on posedge clk and is disabled while rst_n is low.
`ifndef DIODE_CLIPPER_LOG_SHAPER_CORE_DEFINES_SVH
`define DIODE_CLIPPER_LOG_SHAPER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

// Check a condition at every clock edge.
`define DCLS_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed: invariant");

// Check that a condition implies another in the same cycle.
`define DCLS_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

`else

`define DCLS_ASSERT_ALWAYS(lbl, cond)
`define DCLS_ASSERT_IMPLY(lbl, ante, cons)

`endif

`endif

@@ design/dcls_pkg.sv @@
`timescale 1ns / 1ps

package dcls_pkg;

  localparam int LOG_FRAC = 24;   // fraction bits of the log2 result
  localparam int M_W      = 32;   // Q1.31 mantissa
  localparam int INT_W    = 6;    // integer part of log2, 0..32
  localparam int DRV_W    = 48;   // drive_scale width
  localparam int DRV_HALF = 24;   // drive_scale split point
  localparam int OSC_W    = 24;   // out_scale width
  localparam int LN_W     = 34;   // ln result, Q.28
  localparam int Y_W      = 58;   // scaled result, Q.48
  localparam int CFG_IDX_W = 1;

  localparam logic [31:0]      LN2_Q32         = 32'd2977044472;
  localparam logic [OSC_W-1:0] OUT_SCALE_RST   = 24'd47489;
  localparam logic [DRV_W-1:0] DRIVE_SCALE_RST = 48'd26006349218;

  localparam logic [CFG_IDX_W-1:0] CFG_OUT_SCALE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_SCALE = 1'b1;

  // Per-stage control that travels with each sample.
  typedef struct packed {
    logic vld;
    logic last;
    logic byp;   // zero or negative sample: pass through
  } ctl_t;

endpackage

@@ design/diode_clipper_log_shaper_core.sv @@
`timescale 1ns / 1ps
// Channel  Direction  Handshake            Payload
// in       input      in_valid/in_stall    in_sample_in, in_last_in
// out      output     out_valid/out_stall  out_sample_out, out_last_out
// cfg      input      cfg_we               cfg_idx, cfg_wdata
//
// One sample enters per cycle while in_stall is low; 31 register stages plus a
// two-entry output queue lie between the input and out_valid. The depth is set
// by the 24 squaring stages of the log2 fraction, one 32x32 square per stage.
// rst_n is synchronous: it empties the pipeline and queue and reloads both
// registers. The whole pipeline holds while the output queue is full, and
// in_stall is that registered full flag.
`include "diode_clipper_log_shaper_core_defines.svh"

module diode_clipper_log_shaper_core
  import dcls_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample_in,
  input  logic                           in_last_in,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0] out_sample_out,
  output logic                           out_last_out,
  input  logic                           cfg_we,
  input  logic [CFG_IDX_W-1:0]           cfg_idx,
  input  logic [DRV_W-1:0]               cfg_wdata
);

  localparam logic [INT_W-1:0] IP_MAX = 6'd32;

  // Configuration registers; the user must write them only while the block is idle; the block does not enforce it.
  logic [OSC_W-1:0] out_scale_r;
  logic [DRV_W-1:0] drive_scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_scale_r   <= OUT_SCALE_RST;
      drive_scale_r <= DRIVE_SCALE_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_OUT_SCALE:   out_scale_r   <= cfg_wdata[OSC_W-1:0];
        CFG_DRIVE_SCALE: drive_scale_r <= cfg_wdata;
      endcase
    end
  end

  // Global advance: every stage moves while the output queue has room.
  logic en, q_full, q_push;
  ctl_t in_ctl;
  logic [SAMPLE_WIDTH-1:0] in_raw;

  assign en       = !q_full;
  assign in_stall = q_full;
  assign in_raw   = in_sample_in;

  // Mark zero and negative samples for pass-through.
  always_comb begin
    in_ctl.vld  = in_valid;
    in_ctl.last = in_last_in;
    in_ctl.byp  = in_sample_in[SAMPLE_WIDTH-1] || (in_raw == '0);
  end

  // Front: drive multiply, add one, normalize to a Q1.31 mantissa.
  ctl_t                    fr_ctl;
  logic [SAMPLE_WIDTH-1:0] fr_raw;
  logic [M_W-1:0]          fr_m;
  logic [INT_W-1:0]        fr_ip;

  dcls_front #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_ctl      (in_ctl),
    .in_raw      (in_raw),
    .drive_scale (drive_scale_r),
    .out_ctl     (fr_ctl),
    .out_raw     (fr_raw),
    .out_m       (fr_m),
    .out_ip      (fr_ip)
  );

  // Log2 fraction: one bit per stage by repeated squaring.
  ctl_t                    lg_ctl  [LOG_FRAC+1];
  logic [SAMPLE_WIDTH-1:0] lg_raw  [LOG_FRAC+1];
  logic [M_W-1:0]          lg_m    [LOG_FRAC+1];
  logic [INT_W-1:0]        lg_ip   [LOG_FRAC+1];
  logic [LOG_FRAC-1:0]     lg_frac [LOG_FRAC+1];

  assign lg_ctl[0]  = fr_ctl;
  assign lg_raw[0]  = fr_raw;
  assign lg_m[0]    = fr_m;
  assign lg_ip[0]   = fr_ip;
  assign lg_frac[0] = '0;

  for (genvar g = 0; g < LOG_FRAC; g++) begin : g_log
    dcls_logstep #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_ctl   (lg_ctl[g]),
      .in_raw   (lg_raw[g]),
      .in_m     (lg_m[g]),
      .in_ip    (lg_ip[g]),
      .in_frac  (lg_frac[g]),
      .out_ctl  (lg_ctl[g+1]),
      .out_raw  (lg_raw[g+1]),
      .out_m    (lg_m[g+1]),
      .out_ip   (lg_ip[g+1]),
      .out_frac (lg_frac[g+1])
    );
  end

  // Back: ln 2 multiply, output scale, round and saturate, or pass the raw sample through.
  ctl_t                    bk_ctl;
  logic [SAMPLE_WIDTH-1:0] bk_sample;

  dcls_back #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_ctl     (lg_ctl[LOG_FRAC]),
    .in_raw     (lg_raw[LOG_FRAC]),
    .in_ip      (lg_ip[LOG_FRAC]),
    .in_frac    (lg_frac[LOG_FRAC]),
    .out_scale  (out_scale_r),
    .out_ctl    (bk_ctl),
    .out_sample (bk_sample)
  );

  // Push the finished transaction into the output queue as the pipe advances.
  logic [SAMPLE_WIDTH-1:0] q_sample;

  assign q_push = bk_ctl.vld && en;

  dcls_outq #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_outq (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (q_push),
    .push_sample (bk_sample),
    .push_last   (bk_ctl.last),
    .full        (q_full),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_sample  (q_sample),
    .out_last    (out_last_out)
  );

  assign out_sample_out = q_sample;

  // A positive sample always normalizes to a mantissa with its top bit set.
  `DCLS_ASSERT_IMPLY(a_norm_msb, fr_ctl.vld && !fr_ctl.byp, fr_m[M_W-1])
  // The integer part of log2 stays within what the input range allows.
  `DCLS_ASSERT_IMPLY(a_int_range, fr_ctl.vld && !fr_ctl.byp, fr_ip <= IP_MAX)
  // A shaped positive sample never comes out negative.
  `DCLS_ASSERT_IMPLY(a_pos_sign, q_push && !bk_ctl.byp, !bk_sample[SAMPLE_WIDTH-1])
  // The input side stalls only after a result sat stalled at the output.
  `DCLS_ASSERT_IMPLY(a_stall_cause, $rose(in_stall), $past(out_valid && out_stall))

endmodule

@@ design/dcls_front.sv @@
`timescale 1ns / 1ps

module dcls_front
  import dcls_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  ctl_t                    in_ctl,
  input  logic [SAMPLE_WIDTH-1:0] in_raw,
  input  logic [DRV_W-1:0]        drive_scale,
  output ctl_t                    out_ctl,
  output logic [SAMPLE_WIDTH-1:0] out_raw,
  output logic [M_W-1:0]          out_m,
  output logic [INT_W-1:0]        out_ip
);

  localparam int F    = SAMPLE_WIDTH - 2;
  localparam int S_W  = SAMPLE_WIDTH - 1;
  localparam int P_W  = S_W + DRV_HALF;
  localparam int A_W  = SAMPLE_WIDTH + 48;
  localparam int NCH  = (A_W + 15) / 16;
  localparam int AP   = NCH * 16;
  localparam int CS_W = $clog2(NCH);
  localparam int LZ_W = CS_W + 4;

  localparam logic [A_W-1:0]  ONE     = {{(A_W-1){1'b0}}, 1'b1} << (F + 16);
  localparam logic [LZ_W-1:0] IP_BASE = LZ_W'(AP - 17 - F);
  localparam logic [CS_W-1:0] C_TOP   = CS_W'(NCH - 1);

  // stage 1: partial products
  ctl_t                    c1_r;
  logic [SAMPLE_WIDTH-1:0] raw1_r;
  logic [P_W-1:0]          t1_r, t2_r, t1_nxt, t2_nxt;
  logic [S_W-1:0]          s;

  assign s      = in_raw[S_W-1:0];
  assign t1_nxt = {{DRV_HALF{1'b0}}, s} * {{S_W{1'b0}}, drive_scale[DRV_HALF-1:0]};
  assign t2_nxt = {{DRV_HALF{1'b0}}, s} * {{S_W{1'b0}}, drive_scale[DRV_W-1:DRV_HALF]};

  // stage 2: 1 + x*drive_scale
  ctl_t                    c2_r;
  logic [SAMPLE_WIDTH-1:0] raw2_r;
  logic [A_W-1:0]          a_r, a_nxt;

  assign a_nxt = {1'b0, t2_r, {DRV_HALF{1'b0}}} + A_W'(t1_r) + ONE;

  // stage 3: coarse normalize by 16-bit chunks
  ctl_t                    c3_r;
  logic [SAMPLE_WIDTH-1:0] raw3_r;
  logic [AP-1:0]           a_pad, ac_r, ac_nxt;
  logic [CS_W-1:0]         csel, cl_r, cl_nxt;

  assign a_pad = AP'(a_r);

  always_comb begin
    csel = '0;
    for (int k = 0; k < NCH; k++) begin
      if (a_pad[k*16 +: 16] != 16'd0) csel = CS_W'(k);
    end
    cl_nxt = C_TOP - csel;
    ac_nxt = a_pad << {cl_nxt, 4'd0};
  end

  // stage 4: fine normalize inside the top chunk
  ctl_t                    c4_r;
  logic [SAMPLE_WIDTH-1:0] raw4_r;
  logic [M_W-1:0]          m_r, m_nxt;
  logic [INT_W-1:0]        ip_r, ip_nxt;
  logic [3:0]              fsh;
  logic [AP-1:0]           an;
  logic [LZ_W-1:0]         ipw;

  always_comb begin
    fsh = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (ac_r[AP-16+i]) fsh = 4'(15 - i);
    end
    an     = ac_r << fsh;
    m_nxt  = an[AP-1 -: M_W];
    ipw    = IP_BASE - {cl_r, fsh};
    ip_nxt = ipw[INT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r <= '0;
      c2_r <= '0;
      c3_r <= '0;
      c4_r <= '0;
    end else if (en) begin
      c1_r <= in_ctl;
      c2_r <= c1_r;
      c3_r <= c2_r;
      c4_r <= c3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      raw1_r <= in_raw;
      t1_r   <= t1_nxt;
      t2_r   <= t2_nxt;
      raw2_r <= raw1_r;
      a_r    <= a_nxt;
      raw3_r <= raw2_r;
      ac_r   <= ac_nxt;
      cl_r   <= cl_nxt;
      raw4_r <= raw3_r;
      m_r    <= m_nxt;
      ip_r   <= ip_nxt;
    end
  end

  assign out_ctl = c4_r;
  assign out_raw = raw4_r;
  assign out_m   = m_r;
  assign out_ip  = ip_r;

endmodule

@@ design/dcls_logstep.sv @@
`timescale 1ns / 1ps

module dcls_logstep
  import dcls_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  ctl_t                    in_ctl,
  input  logic [SAMPLE_WIDTH-1:0] in_raw,
  input  logic [M_W-1:0]          in_m,
  input  logic [INT_W-1:0]        in_ip,
  input  logic [LOG_FRAC-1:0]     in_frac,
  output ctl_t                    out_ctl,
  output logic [SAMPLE_WIDTH-1:0] out_raw,
  output logic [M_W-1:0]          out_m,
  output logic [INT_W-1:0]        out_ip,
  output logic [LOG_FRAC-1:0]     out_frac
);

  ctl_t                    ctl_r;
  logic [SAMPLE_WIDTH-1:0] raw_r;
  logic [M_W-1:0]          m_r, m_nxt;
  logic [INT_W-1:0]        ip_r;
  logic [LOG_FRAC-1:0]     frac_r, frac_nxt;
  logic [2*M_W-1:0]        sq;
  logic [M_W:0]            t;

  // square, and halve when the square reaches 2.0
  always_comb begin
    sq       = {{M_W{1'b0}}, in_m} * {{M_W{1'b0}}, in_m};
    t        = sq[2*M_W-1:M_W-1];
    m_nxt    = t[M_W] ? t[M_W:1] : t[M_W-1:0];
    frac_nxt = {in_frac[LOG_FRAC-2:0], t[M_W]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      raw_r  <= in_raw;
      m_r    <= m_nxt;
      ip_r   <= in_ip;
      frac_r <= frac_nxt;
    end
  end

  assign out_ctl  = ctl_r;
  assign out_raw  = raw_r;
  assign out_m    = m_r;
  assign out_ip   = ip_r;
  assign out_frac = frac_r;

endmodule

@@ design/dcls_back.sv @@
`timescale 1ns / 1ps

module dcls_back
  import dcls_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  ctl_t                    in_ctl,
  input  logic [SAMPLE_WIDTH-1:0] in_raw,
  input  logic [INT_W-1:0]        in_ip,
  input  logic [LOG_FRAC-1:0]     in_frac,
  input  logic [OSC_W-1:0]        out_scale,
  output ctl_t                    out_ctl,
  output logic [SAMPLE_WIDTH-1:0] out_sample
);

  localparam int F    = SAMPLE_WIDTH - 2;
  localparam int LB_W = INT_W + LOG_FRAC;
  localparam int PR_W = LB_W + 32;

  localparam logic [PR_W-1:0] LN_RND = {{(PR_W-1){1'b0}}, 1'b1} << 27;
  localparam logic [Y_W:0]    Y_RND  = {{Y_W{1'b0}}, 1'b1} << (47 - F);
  localparam logic [SAMPLE_WIDTH-1:0] MAXV = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};

  // stage A: multiply by ln 2
  ctl_t                    ca_r;
  logic [SAMPLE_WIDTH-1:0] rawa_r;
  logic [LN_W-1:0]         lnq_r, lnq_nxt;
  logic [LB_W-1:0]         lbits;
  logic [PR_W-1:0]         lprod;

  always_comb begin
    lbits   = {in_ip, in_frac};
    lprod   = {32'd0, lbits} * {{LB_W{1'b0}}, LN2_Q32} + LN_RND;
    lnq_nxt = lprod[PR_W-1:28];
  end

  // stage B: multiply by out_scale
  ctl_t                    cb_r;
  logic [SAMPLE_WIDTH-1:0] rawb_r;
  logic [Y_W-1:0]          y_r, y_nxt;

  assign y_nxt = {{OSC_W{1'b0}}, lnq_r} * {{LN_W{1'b0}}, out_scale};

  // stage C: round, saturate, pick bypass
  ctl_t                    cc_r;
  logic [SAMPLE_WIDTH-1:0] res_r, res_nxt;
  logic [Y_W:0]            ysum;
  logic                    ovf;

  always_comb begin
    ysum = {1'b0, y_r} + Y_RND;
    ovf  = |ysum[Y_W:49];
    if (cb_r.byp) begin
      res_nxt = rawb_r;
    end else if (ovf) begin
      res_nxt = MAXV;
    end else begin
      res_nxt = {1'b0, ysum[48 -: SAMPLE_WIDTH-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ca_r <= '0;
      cb_r <= '0;
      cc_r <= '0;
    end else if (en) begin
      ca_r <= in_ctl;
      cb_r <= ca_r;
      cc_r <= cb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rawa_r <= in_raw;
      lnq_r  <= lnq_nxt;
      rawb_r <= rawa_r;
      y_r    <= y_nxt;
      res_r  <= res_nxt;
    end
  end

  assign out_ctl    = cc_r;
  assign out_sample = res_r;

endmodule

@@ design/dcls_outq.sv @@
`timescale 1ns / 1ps

module dcls_outq #(
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  logic [SAMPLE_WIDTH-1:0] push_sample,
  input  logic                    push_last,
  output logic                    full,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [SAMPLE_WIDTH-1:0] out_sample,
  output logic                    out_last
);

  localparam int D_W = SAMPLE_WIDTH + 1;

  logic [D_W-1:0] ent0_r, ent0_nxt, ent1_r, ent1_nxt, din;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           pop;

  assign din = {push_last, push_sample};
  assign pop = (cnt_r != 2'd0) && !out_stall;

  always_comb begin
    ent0_nxt = ent0_r;
    ent1_nxt = ent1_r;
    cnt_nxt  = cnt_r;
    if (pop && !push) begin
      ent0_nxt = ent1_r;
      cnt_nxt  = cnt_r - 2'd1;
    end else if (push && !pop) begin
      if (cnt_r == 2'd0) ent0_nxt = din;
      else ent1_nxt = din;
      cnt_nxt = cnt_r + 2'd1;
    end else if (push && pop) begin
      if (cnt_r == 2'd1) begin
        ent0_nxt = din;
      end else begin
        ent0_nxt = ent1_r;
        ent1_nxt = din;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent0_r <= ent0_nxt;
    ent1_r <= ent1_nxt;
  end

  assign full       = (cnt_r == 2'd2);
  assign out_valid  = (cnt_r != 2'd0);
  assign out_sample = ent0_r[SAMPLE_WIDTH-1:0];
  assign out_last   = ent0_r[SAMPLE_WIDTH];

endmodule

@@ tb/tb_diode_clipper_log_shaper_core.sv @@
`timescale 1ns / 1ps

module tb_diode_clipper_log_shaper_core;
  import dcls_pkg::*;

  localparam int SW          = 24;
  localparam int FRAC        = SW - 2;         // Q1.22 samples
  localparam int PROD_FRAC   = FRAC + 16;      // fraction bits of sample * drive_scale
  localparam int TAIL_CYCLES = 40;             // pipeline plus output queue, with margin
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 190;
  localparam int HOLD_CYCLES = 300;

  typedef logic signed [SW-1:0] sample_t;

  // One sample the block still owes us.
  typedef struct {
    sample_t level;
    logic    last;
    bit      shaped;   // took the log path, so rounding slack applies
  } owed_sample_t;

  class clip_scoreboard;
    bit [OSC_W-1:0] out_scale;
    bit [DRV_W-1:0] drive_scale;
    owed_sample_t   owed[$];
    int             failures;
    int             accepted;
    int             shaped_cnt;
    int             clipped_cnt;

    function new();
      out_scale   = OUT_SCALE_RST;
      drive_scale = DRIVE_SCALE_RST;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DRV_W-1:0] data);
      if (idx == CFG_OUT_SCALE)
        out_scale = data[OSC_W-1:0];
      else if (idx == CFG_DRIVE_SCALE)
        drive_scale = data;
    endfunction

    // out_scale * ln(1 + s * drive_scale) for a positive sample, in the block's
    // fixed-point steps: normalize, log2 by repeated squaring, times ln 2, scale.
    function sample_t diode_curve(bit [SW-1:0] s);
      bit [127:0] acc;
      bit [63:0]  mant;
      bit [127:0] lbits;
      bit [127:0] ln_q;
      bit [127:0] scaled;
      bit [127:0] rounded;
      bit [23:0]  frac;
      int         top;
      acc = 128'(s) * 128'(drive_scale) + (128'd1 << PROD_FRAC);
      top = 127;
      while (!acc[top])
        top--;
      // acc >= 2^PROD_FRAC, so the top bit is always above bit 31
      mant = 64'((acc >> (top - 31)) & 128'hFFFF_FFFF);
      frac = '0;
      for (int i = 0; i < LOG_FRAC; i++) begin
        mant = (mant * mant) >> 31;
        frac = frac << 1;
        if (mant[32]) begin
          mant  = mant >> 1;
          frac[0] = 1'b1;
        end
      end
      lbits   = (128'(top - PROD_FRAC) << LOG_FRAC) | 128'(frac);
      ln_q    = (lbits * 128'(LN2_Q32) + (128'd1 << 27)) >> 28;
      scaled  = ln_q * 128'(out_scale);
      rounded = (scaled + (128'd1 << (47 - FRAC))) >> (48 - FRAC);
      if (rounded > 128'((1 << (SW - 1)) - 1)) begin
        clipped_cnt++;
        rounded = 128'((1 << (SW - 1)) - 1);
      end
      return sample_t'(rounded[SW-1:0]);
    endfunction

    function void note_sample(sample_t s, logic last);
      owed_sample_t o;
      o.last   = last;
      o.shaped = !s[SW-1] && (s != 0);
      o.level  = o.shaped ? diode_curve(s) : s;
      accepted++;
      if (o.shaped)
        shaped_cnt++;
      owed.push_back(o);
    endfunction

    function void check_sample(sample_t got, logic got_last);
      owed_sample_t o;
      int           diff;
      if (owed.size() == 0) begin
        $error("sample_out: result 0x%0h arrived with no sample outstanding", got);
        failures++;
        return;
      end
      o    = owed.pop_front();
      diff = o.level - got;
      if ($isunknown(got) || (o.shaped ? (diff > 2 || diff < -2) : (got !== o.level))) begin
        $error("sample_out: expected %0d, actual %0d", o.level, got);
        failures++;
      end
      if (got_last !== o.last) begin
        $error("last_out: expected %0b, actual %0b", o.last, got_last);
        failures++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  sample_t               in_sample_in;
  logic                  in_last_in;
  logic                  out_valid;
  logic                  out_stall;
  sample_t               out_sample_out;
  logic                  out_last_out;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [DRV_W-1:0]      cfg_wdata;

  clip_scoreboard board;
  int             cycle_count;
  int             send_idle_pct;
  int             stall_pct;
  bit             hold_request;
  int             hold_left;
  int             settings_used;

  diode_clipper_log_shaper_core #(
    .SAMPLE_WIDTH(SW)
  ) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample_in   (in_sample_in),
    .in_last_in     (in_last_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample_out (out_sample_out),
    .out_last_out   (out_last_out),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_wdata      (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Count cycles; bail out if the run hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles, %0d samples still outstanding",
             cycle_count, board.owed.size());
    $display("Test completed with failures");
    $finish;
  end

  // Record every input transaction; values seen here are the pre-edge ones.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      board.note_sample(in_sample_in, in_last_in);
  end

  // Check every output transaction against the oldest owed sample.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_sample(out_sample_out, out_last_out);
  end

  // Receiver: random stall at stall_pct, or a long hold-off on request so
  // the pipeline and queue fill and in_stall rises.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Offer one sample; idle first at send_idle_pct. Return at the accepting
  // edge with in_valid still high, so back-to-back items need one assignment.
  task automatic send_sample(input sample_t s, input logic last);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct)
      gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_sample_in <= s;
    in_last_in   <= last;
    do
      @(posedge clk);
    while (in_stall);
  endtask

  // Drop valid and hold until every owed sample is back.
  task automatic drain;
    in_valid <= 1'b0;
    while (board.owed.size() != 0)
      @(posedge clk);
    @(posedge clk);
  endtask

  // Write both registers back to back; only called with the block empty.
  task automatic program_clipper(input logic [DRV_W-1:0] os_word,
                                 input logic [DRV_W-1:0] ds_word);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_OUT_SCALE;
    cfg_wdata <= os_word;
    @(posedge clk);
    board.write_reg(CFG_OUT_SCALE, os_word);
    cfg_idx   <= CFG_DRIVE_SCALE;
    cfg_wdata <= ds_word;
    @(posedge clk);
    board.write_reg(CFG_DRIVE_SCALE, ds_word);
    cfg_we    <= 1'b0;
    settings_used++;
  endtask

  // Mix of negative, zero, tiny positive and full-range positive samples.
  function automatic sample_t pick_sample();
    case ($urandom_range(9))
      0, 1, 2: return {1'b1, 23'($urandom)};
      3: begin
        case ($urandom_range(4))
          0:       return '0;
          1:       return 24'sd1;
          2:       return 24'sh7FFFFF;
          3:       return 24'sh800000;
          default: return -24'sd1;
        endcase
      end
      4, 5:    return sample_t'($urandom_range(4095, 1));
      default: return {1'b0, 23'($urandom)};
    endcase
  endfunction

  // Random drive spread over its whole magnitude range; never zero.
  function automatic logic [DRV_W-1:0] pick_drive();
    logic [DRV_W-1:0] d;
    d = {16'($urandom), $urandom} >> $urandom_range(47);
    return (d == '0) ? 48'd1 : d;
  endfunction

  initial begin
    sample_t          s;
    logic [DRV_W-1:0] os_word;
    logic [DRV_W-1:0] ds_word;
    board         = new();
    cycle_count   = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_request  = 1'b0;
    hold_left     = 0;
    settings_used = 0;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_sample_in <= '0;
    in_last_in   <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_idx      <= CFG_OUT_SCALE;
    cfg_wdata    <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset registers, pass-through at zero and below, field extremes.
    send_sample('0, 1'b1);
    send_sample(24'sd1, 1'b0);
    send_sample(24'sd2, 1'b0);
    send_sample(24'sh7FFFFF, 1'b1);
    send_sample(-24'sd1, 1'b0);
    send_sample(24'sh800000, 1'b1);
    send_sample(24'sh400000, 1'b0);
    send_sample(24'sh000100, 1'b0);
    drain();

    // Overdrive: both registers at their top, upper write bits all ones.
    program_clipper(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    send_sample(24'sh7FFFFF, 1'b0);
    send_sample(24'sd1, 1'b1);
    send_sample(24'sd100, 1'b0);
    send_sample(-24'sd7, 1'b0);
    drain();

    // Zero drive: ln(1) gives zero for every positive sample.
    program_clipper(48'd47489, 48'd0);
    send_sample(24'sd1, 1'b0);
    send_sample(24'sh7FFFFF, 1'b1);
    send_sample(-24'sd3, 1'b0);
    drain();

    // Zero output scale, smallest legal drive.
    program_clipper(48'hABCD_0000_0000, 48'd1);
    send_sample(24'sh7FFFFF, 1'b0);
    send_sample(24'sd12345, 1'b1);
    drain();

    // Random phases: rotate register settings and idling modes.
    for (int p = 0; p < 8; p++) begin
      case (p)
        0, 5: begin
          os_word = 48'(OUT_SCALE_RST);
          ds_word = DRIVE_SCALE_RST;
        end
        1: begin
          os_word = 48'hFFFF_FFFF_FFFF;
          ds_word = 48'hFFFF_FFFF_FFFF;
        end
        3: begin
          os_word = {24'($urandom), 24'd0};
          ds_word = 48'd1;
        end
        default: begin
          os_word = {24'($urandom), 24'($urandom)};
          ds_word = pick_drive();
        end
      endcase
      program_clipper(os_word, ds_word);

      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 78; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 78; end
        default: begin send_idle_pct = 34; stall_pct = 34; end
      endcase
      // Long receiver hold-off while the sender keeps pushing at full rate.
      if (p == 4)
        hold_request = 1'b1;

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // Keep stretches without idling inside the idling phases too.
        if (i == PHASE_ITEMS / 2 && p % 4 != 0) begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        s = pick_sample();
        send_sample(s, ($urandom_range(7) == 0));
      end
      drain();
    end

    stall_pct = 0;
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Shaped %0d of %0d samples (%0d clipped at full scale) over %0d register settings",
             board.shaped_cnt, board.accepted, board.clipped_cnt, settings_used + 1);
    $display("Idling modes: none, sender 78%%, receiver 78%%, both 34%%, plus a %0d-cycle hold-off",
             HOLD_CYCLES);
    if (board.failures == 0 && board.owed.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+design
design/dcls_pkg.sv
design/dcls_front.sv
design/dcls_logstep.sv
design/dcls_back.sv
design/dcls_outq.sv
design/diode_clipper_log_shaper_core.sv
tb/tb_diode_clipper_log_shaper_core.sv
